// File: rtl/core/rrq_pkg.sv
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared constants and types for the round-robin run queue: sizes, opcode
// and policy codes, and the controller-to-datapath command word.
// ----------------------------------------------------------------------------
package rrq_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int SLICE_W   = 10;

    localparam logic [SLICE_W-1:0] SLICE_RELOAD_RESET = SLICE_W'(10);

    typedef enum logic [2:0] {
        OP_ENQUEUE = 3'd0,
        OP_DEQUEUE = 3'd1,
        OP_YIELD   = 3'd2,
        OP_PICK    = 3'd3,
        OP_TICK    = 3'd4,
        OP_PREEMPT = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        POL_NORMAL = 2'd0,
        POL_FIFO   = 2'd1,
        POL_RR     = 2'd2,
        POL_WRR    = 2'd3
    } policy_t;

    typedef struct packed {
        logic capture;   // latch the incoming word
        logic look;      // search the queue for the slot
        logic apply;     // update queue, flags and slices
        logic load_out;  // load the result register
    } rrq_cmd_t;

endpackage

// File: rtl/core/rrq_request_if.sv
// ----------------------------------------------------------------------------
// rrq_request_if
// Request channel of the run queue: opcode, slot and policy.
// ----------------------------------------------------------------------------
interface rrq_request_if;

    logic                       valid;
    logic                       ready;
    logic [2:0]                 opcode;
    logic [rrq_pkg::SLOT_W-1:0] task_slot;
    logic [1:0]                 task_policy;

    modport source (output valid, output opcode, output task_slot, output task_policy,
                    input ready);
    modport sink   (input valid, input opcode, input task_slot, input task_policy,
                    output ready);

endinterface

// File: rtl/core/rrq_result_if.sv
// ----------------------------------------------------------------------------
// rrq_result_if
// Result channel of the run queue: head slot, head valid and reschedule flag.
// ----------------------------------------------------------------------------
interface rrq_result_if;

    logic                       valid;
    logic                       ready;
    logic [rrq_pkg::SLOT_W-1:0] head_task;
    logic                       head_valid;
    logic                       need_resched;

    modport source (output valid, output head_task, output head_valid,
                    output need_resched, input ready);
    modport sink   (input valid, input head_task, input head_valid,
                    input need_resched, output ready);

endinterface

// File: rtl/core/round_robin_run_queue.sv
// ----------------------------------------------------------------------------
// round_robin_run_queue
// Ordered run queue of task slots with a time slice per slot.
// ----------------------------------------------------------------------------
// Each request word goes through accept, search of the queue
// (all positions compared at once), update of order, flags and slice, then
// load of the result register. The result register frees the request side,
// so a new word is taken while the previous result still waits; a result not
// taken stalls the sequencer only when the next one is ready to go out.
// slice_reload is written through cfg_we/cfg_wdata and resets to 10.
// ----------------------------------------------------------------------------
module round_robin_run_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    rrq_request_if.sink                 request,
    rrq_result_if.source                result,
    input  logic                        cfg_we,
    input  logic [rrq_pkg::SLICE_W-1:0] cfg_wdata
);
    import rrq_pkg::*;

    rrq_cmd_t cmd;

    rrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .cmd       (cmd)
    );

    rrq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (request.opcode),
        .task_slot    (request.task_slot),
        .task_policy  (request.task_policy),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .head_task    (result.head_task),
        .head_valid   (result.head_valid),
        .need_resched (result.need_resched)
    );

endmodule

// File: rtl/core/rrq_ctrl.sv
// ----------------------------------------------------------------------------
// rrq_ctrl
// Sequencer of the run queue: accept, search, update, then hand the result
// word to the output register.
// ----------------------------------------------------------------------------
module rrq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              res_valid,
    input  logic              res_ready,
    output rrq_pkg::rrq_cmd_t cmd
);
    import rrq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOOK  = 4'b0010,
        ST_APPLY = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;

    always_comb
    begin
        cmd.capture  = (state_reg == ST_IDLE) && req_valid;
        cmd.look     = (state_reg == ST_LOOK);
        cmd.apply    = (state_reg == ST_APPLY);
        cmd.load_out = (state_reg == ST_OUT) && (!res_valid_reg || res_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (req_valid) state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_APPLY;
            ST_APPLY: state_next = ST_OUT;
            ST_OUT:   if (cmd.load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == ST_LOOK))
        else $error("accepted word did not start a search");

    a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && res_valid_reg && !res_ready) |=> (state_reg == ST_OUT))
        else $error("result overwritten while previous word pending");
`endif

endmodule

// File: rtl/core/rrq_datapath.sv
// ----------------------------------------------------------------------------
// rrq_datapath
// Queue order, membership flags, slice counters and the result register.
// ----------------------------------------------------------------------------
module rrq_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rrq_pkg::rrq_cmd_t          cmd,
    input  logic [2:0]                 opcode,
    input  logic [rrq_pkg::SLOT_W-1:0] task_slot,
    input  logic [1:0]                 task_policy,
    input  logic                       cfg_we,
    input  logic [rrq_pkg::SLICE_W-1:0] cfg_wdata,
    output logic [rrq_pkg::SLOT_W-1:0] head_task,
    output logic                       head_valid,
    output logic                       need_resched
);
    import rrq_pkg::*;

    // latched request
    opcode_t                           op_reg;
    logic [SLOT_W-1:0]                 slot_reg;
    policy_t                           policy_reg;

    // queue state
    logic [MAX_TASKS-1:0][SLOT_W-1:0]  list_reg;
    logic [MAX_TASKS-1:0][SLOT_W-1:0]  list_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [MAX_TASKS-1:0]              flags_reg;
    logic [MAX_TASKS-1:0]              flags_next;
    logic [SLICE_W-1:0]                slice_reg [MAX_TASKS];
    logic [SLICE_W-1:0]                reload_reg;

    // search results
    logic [MAX_TASKS-1:0]              match;
    logic [MAX_TASKS-1:0]              shift_next;
    logic [MAX_TASKS-1:0]              shift_reg;
    logic                              queued_reg;
    logic [SLICE_W-1:0]                slice_cur_reg;

    logic                              resched_reg;
    logic                              resched_next;
    logic                              slice_we;
    logic [SLICE_W-1:0]                slice_wdata;

    logic [MAX_TASKS-1:0][SLOT_W-1:0]  list_up;
    logic [MAX_TASKS-1:0][SLOT_W-1:0]  list_removed;
    logic [MAX_TASKS-1:0][SLOT_W-1:0]  list_rotated;
    logic                              slot_ok;

    logic [SLOT_W-1:0]                 head_task_reg;
    logic                              head_valid_reg;
    logic                              need_resched_reg;

    assign slot_ok = CNT_W'(slot_reg) < CNT_W'(MAX_TASKS);

    // every entry at or after the slot's position moves up one place
    always_comb
    begin
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            match[i] = (CNT_W'(i) < count_reg) && (list_reg[i] == slot_reg);
        end
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            shift_next[i] = |(match & MAX_TASKS'((2 << i) - 1));
        end
    end

    assign list_up = {slot_reg, list_reg[MAX_TASKS-1:1]};

    always_comb
    begin
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            list_removed[i] = shift_reg[i] ? list_up[i] : list_reg[i];
            if (shift_reg[i] && (CNT_W'(i) + CNT_W'(1) == count_reg))
            begin
                list_rotated[i] = slot_reg;
            end
            else
            begin
                list_rotated[i] = list_removed[i];
            end
        end
    end

    always_comb
    begin
        list_next    = list_reg;
        count_next   = count_reg;
        flags_next   = flags_reg;
        resched_next = resched_reg;
        slice_we     = 1'b0;
        slice_wdata  = reload_reg;
        if (cmd.apply)
        begin
            resched_next = 1'b0;
            case (op_reg)
                OP_ENQUEUE:
                begin
                    if (slot_ok && !queued_reg && count_reg < CNT_W'(MAX_TASKS))
                    begin
                        list_next[count_reg[SLOT_W-1:0]] = slot_reg;
                        count_next                       = count_reg + CNT_W'(1);
                        flags_next[slot_reg]             = 1'b1;
                        slice_we                         = 1'b1;
                    end
                end
                OP_DEQUEUE:
                begin
                    if (queued_reg)
                    begin
                        list_next            = list_removed;
                        count_next           = count_reg - CNT_W'(1);
                        flags_next[slot_reg] = 1'b0;
                    end
                end
                OP_YIELD:
                begin
                    if (queued_reg)
                    begin
                        list_next = list_rotated;
                    end
                end
                OP_TICK:
                begin
                    if (queued_reg && policy_reg == POL_WRR)
                    begin
                        slice_we = 1'b1;
                        if (slice_cur_reg <= SLICE_W'(1))
                        begin
                            list_next    = list_rotated;
                            resched_next = 1'b1;
                        end
                        else
                        begin
                            slice_wdata = slice_cur_reg - SLICE_W'(1);
                        end
                    end
                end
                OP_PREEMPT:
                begin
                    resched_next = (policy_reg == POL_NORMAL);
                end
                default:
                begin
                    resched_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            flags_reg  <= '0;
            reload_reg <= SLICE_RELOAD_RESET;
        end
        else
        begin
            count_reg <= count_next;
            flags_reg <= flags_next;
            if (cfg_we)
            begin
                reload_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg    <= list_next;
        resched_reg <= resched_next;
        if (cmd.capture)
        begin
            op_reg     <= opcode_t'(opcode);
            slot_reg   <= task_slot;
            policy_reg <= policy_t'(task_policy);
        end
        if (cmd.look)
        begin
            shift_reg     <= shift_next;
            queued_reg    <= slot_ok && flags_reg[slot_reg];
            slice_cur_reg <= slice_reg[slot_reg];
        end
        if (slice_we)
        begin
            slice_reg[slot_reg] <= slice_wdata;
        end
        if (cmd.load_out)
        begin
            head_task_reg    <= (count_reg != '0) ? list_reg[0] : '0;
            head_valid_reg   <= (count_reg != '0);
            need_resched_reg <= resched_reg;
        end
    end

    assign head_task    = head_task_reg;
    assign head_valid   = head_valid_reg;
    assign need_resched = need_resched_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("queue count above capacity");

    a_flags_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(flags_reg) == int'(count_reg))
        else $error("membership flags disagree with queue count");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.look |-> $onehot0(match))
        else $error("slot found at more than one queue position");
`endif

endmodule

// File: verif/round_robin_run_queue_tb.sv
// ----------------------------------------------------------------------------
// round_robin_run_queue_tb
// Self-checking bench for the run queue. A short table of directed words
// (empty queue, absent and duplicate slots, yield, tick expiry, unused
// opcodes) is followed by random phases under several slice reload values.
// Each accepted word is run through a local scheduler model and the result
// stream is compared field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module round_robin_run_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rrq_pkg::*;

    localparam logic [2:0] OP_RSVD6     = 3'd6;
    localparam logic [2:0] OP_RSVD7     = 3'd7;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         PHASE_WORDS  = 54;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic              head_ok;
        logic              resched;
    } sched_result_t;

    typedef struct packed {
        logic                is_cfg;
        logic [SLICE_W-1:0]  cfg_value;
        logic [2:0]          op;
        logic [SLOT_W-1:0]   slot;
        logic [1:0]          pol;
        logic                typed;
        sched_result_t       want;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [23] = '{
        '{1'b0, 10'd0,    OP_PICK,    4'd0,  POL_NORMAL, 1'b1, '{4'd0,  1'b0, 1'b0}},
        '{1'b0, 10'd0,    OP_PREEMPT, 4'd9,  POL_NORMAL, 1'b1, '{4'd0,  1'b0, 1'b1}},
        '{1'b0, 10'd0,    OP_PREEMPT, 4'd9,  POL_WRR,    1'b1, '{4'd0,  1'b0, 1'b0}},
        '{1'b0, 10'd0,    OP_DEQUEUE, 4'd5,  POL_NORMAL, 1'b1, '{4'd0,  1'b0, 1'b0}},
        '{1'b0, 10'd0,    OP_TICK,    4'd5,  POL_WRR,    1'b1, '{4'd0,  1'b0, 1'b0}},
        '{1'b0, 10'd0,    OP_ENQUEUE, 4'd15, POL_FIFO,   1'b1, '{4'd15, 1'b1, 1'b0}},
        '{1'b0, 10'd0,    OP_TICK,    4'd15, POL_WRR,    1'b1, '{4'd15, 1'b1, 1'b0}},
        '{1'b1, 10'd2,    OP_PICK,    4'd0,  POL_NORMAL, 1'b0, '0},
        '{1'b0, 10'd0,    OP_ENQUEUE, 4'd0,  POL_RR,     1'b1, '{4'd15, 1'b1, 1'b0}},
        '{1'b0, 10'd0,    OP_ENQUEUE, 4'd15, POL_NORMAL, 1'b1, '{4'd15, 1'b1, 1'b0}},
        '{1'b0, 10'd0,    OP_YIELD,   4'd15, POL_FIFO,   1'b1, '{4'd0,  1'b1, 1'b0}},
        '{1'b0, 10'd0,    OP_TICK,    4'd15, POL_RR,     1'b0, '0},
        '{1'b0, 10'd0,    OP_TICK,    4'd0,  POL_WRR,    1'b0, '0},
        '{1'b0, 10'd0,    OP_TICK,    4'd0,  POL_WRR,    1'b1, '{4'd15, 1'b1, 1'b1}},
        '{1'b0, 10'd0,    OP_RSVD6,   4'd3,  POL_FIFO,   1'b0, '0},
        '{1'b0, 10'd0,    OP_RSVD7,   4'd12, POL_WRR,    1'b0, '0},
        '{1'b0, 10'd0,    OP_ENQUEUE, 4'd7,  POL_WRR,    1'b0, '0},
        '{1'b0, 10'd0,    OP_DEQUEUE, 4'd0,  POL_NORMAL, 1'b0, '0},
        '{1'b0, 10'd0,    OP_YIELD,   4'd3,  POL_RR,     1'b0, '0},
        '{1'b0, 10'd0,    OP_DEQUEUE, 4'd15, POL_FIFO,   1'b0, '0},
        '{1'b0, 10'd0,    OP_PREEMPT, 4'd7,  POL_FIFO,   1'b0, '0},
        '{1'b0, 10'd0,    OP_PICK,    4'd7,  POL_RR,     1'b0, '0},
        '{1'b0, 10'd0,    OP_DEQUEUE, 4'd7,  POL_WRR,    1'b0, '0}
    };

    localparam logic [SLICE_W-1:0] PHASE_RELOADS [7] = '{
        10'd1, 10'd1023, 10'd3, 10'd0, 10'd2, 10'd10, 10'd6
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [SLICE_W-1:0] cfg_wdata;

    rrq_request_if req_bus ();
    rrq_result_if  res_bus ();

    round_robin_run_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_bus),
        .result    (res_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // scheduler model state
    logic [SLOT_W-1:0]  run_order   [MAX_TASKS];
    int                 run_count;
    logic               slot_queued [MAX_TASKS];
    logic [SLICE_W-1:0] slot_slice  [MAX_TASKS];
    logic [SLICE_W-1:0] slice_reload_q;

    sched_result_t      pending_heads [$];
    int                 error_count;
    int                 cycle_count;
    int                 burst_left;
    int                 result_index;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        error_count++;
        $display("%0t result %0d: %s expected %0d got %0d",
                 $time, result_index, what, want_v, got_v);
    endtask

    function automatic int slot_position(input logic [SLOT_W-1:0] slot);
        int pos;
        pos = run_count;
        for (int i = run_count - 1; i >= 0; i--)
            if (run_order[i] == slot)
                pos = i;
        return pos;
    endfunction

    function automatic void drop_at(input int pos);
        for (int i = pos; i + 1 < run_count; i++)
            run_order[i] = run_order[i + 1];
        run_count--;
    endfunction

    function automatic void rotate_to_tail(input logic [SLOT_W-1:0] slot);
        int pos;
        pos = slot_position(slot);
        if (pos < run_count)
        begin
            drop_at(pos);
            run_order[run_count] = slot;
            run_count++;
        end
    endfunction

    function automatic sched_result_t step_run_queue(input logic [2:0] op,
                                                     input logic [SLOT_W-1:0] slot,
                                                     input logic [1:0] pol);
        sched_result_t res;
        logic          queued;
        queued      = slot_queued[slot];
        res.resched = 1'b0;
        case (op)
            OP_ENQUEUE:
                if (!queued && run_count < MAX_TASKS)
                begin
                    run_order[run_count] = slot;
                    run_count++;
                    slot_queued[slot] = 1'b1;
                    slot_slice[slot]  = slice_reload_q;
                end
            OP_DEQUEUE:
                if (queued)
                begin
                    drop_at(slot_position(slot));
                    slot_queued[slot] = 1'b0;
                end
            OP_YIELD:
                if (queued)
                begin
                    rotate_to_tail(slot);
                end
            OP_TICK:
                if (queued && pol == POL_WRR)
                begin
                    // an empty slice expires as well as one running out now
                    if (slot_slice[slot] <= 1)
                    begin
                        slot_slice[slot] = slice_reload_q;
                        rotate_to_tail(slot);
                        res.resched = 1'b1;
                    end
                    else
                        slot_slice[slot] = slot_slice[slot] - 1'b1;
                end
            OP_PREEMPT:
            begin
                res.resched = (pol == POL_NORMAL);
            end
            default: ;
        endcase
        res.head_ok = (run_count > 0);
        res.head    = (run_count > 0) ? run_order[0] : '0;
        return res;
    endfunction

    // Drive one word; the gap before it, if any, comes from the burst pattern.
    task automatic send_word(input logic [2:0] op, input logic [SLOT_W-1:0] slot,
                             input logic [1:0] pol, input logic typed,
                             input sched_result_t want);
        int            gap;
        sched_result_t pred;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_bus.valid       <= 1'b1;
        req_bus.opcode      <= op;
        req_bus.task_slot   <= slot;
        req_bus.task_policy <= pol;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        pred = step_run_queue(op, slot, pol);
        pending_heads.push_back(typed ? want : pred);
    endtask

    task automatic write_slice_reload(input logic [SLICE_W-1:0] value);
        while (pending_heads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we         <= 1'b0;
        slice_reload_q  = value;
    endtask

    task automatic run_random_phase(input int target, input int fill_bias);
        int                sent;
        int                roll;
        logic [2:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [1:0]        pol;
        sent = 0;
        while (sent < target)
        begin
            roll = $urandom_range(0, 99);
            slot = SLOT_W'($urandom_range(0, MAX_TASKS - 1));
            pol  = 2'($urandom_range(0, 3));
            if (roll < 25 + fill_bias)
                op = OP_ENQUEUE;
            else if (roll < 40)
                op = OP_DEQUEUE;
            else if (roll < 52)
                op = OP_YIELD;
            else if (roll < 82)
                op = OP_TICK;
            else if (roll < 88)
                op = OP_PICK;
            else if (roll < 94)
                op = OP_PREEMPT;
            else
                op = ($urandom_range(0, 1) == 0) ? OP_RSVD6 : OP_RSVD7;
            // aim most slot operations at a queued slot, usually the running one
            if ((op == OP_DEQUEUE || op == OP_YIELD || op == OP_TICK) && run_count > 0
                && $urandom_range(0, 4) != 0)
                slot = ($urandom_range(0, 2) != 0) ? run_order[0]
                                                   : run_order[$urandom_range(0, run_count - 1)];
            if (op == OP_TICK && $urandom_range(0, 3) != 0)
                pol = POL_WRR;
            send_word(op, slot, pol, 1'b0, '0);
            sent++;
        end
        req_bus.valid <= 1'b0;
    endtask

    // Result side: check each accepted word, then pick the next ready value.
    always @(posedge clk)
    begin : result_monitor
        sched_result_t want;
        int            stall_mode;
        int            stall_left;
        logic [31:0]   stall_pattern;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_heads.size() == 0)
                report_mismatch("result with nothing pending, head_task", 0,
                                int'(res_bus.head_task));
            else
            begin
                want = pending_heads.pop_front();
                if (res_bus.head_task !== want.head)
                    report_mismatch("head_task", int'(want.head), int'(res_bus.head_task));
                if (res_bus.head_valid !== want.head_ok)
                    report_mismatch("head_valid", int'(want.head_ok),
                                    int'(res_bus.head_valid));
                if (res_bus.need_resched !== want.resched)
                    report_mismatch("need_resched", int'(want.resched),
                                    int'(res_bus.need_resched));
            end
            result_index++;
        end
        if (stall_left <= 0)
        begin
            stall_mode    = $urandom_range(0, 3);
            stall_left    = $urandom_range(16, 80);
            stall_pattern = $urandom;
        end
        stall_left--;
        case (stall_mode)
            0: res_bus.ready <= 1'b1;
            1: res_bus.ready <= ($urandom_range(0, 3) != 0);
            2: res_bus.ready <= stall_pattern[cycle_count % 32];
            default: res_bus.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL round_robin_run_queue");
        $finish;
    end

    initial
    begin
        burst_left     = 0;
        run_count      = 0;
        slice_reload_q = SLICE_RELOAD_RESET;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            run_order[i]   = '0;
            slot_queued[i] = 1'b0;
            slot_slice[i]  = '0;
        end
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.opcode      <= '0;
        req_bus.task_slot   <= '0;
        req_bus.task_policy <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].is_cfg)
            begin
                req_bus.valid <= 1'b0;
                write_slice_reload(DIRECTED_ROWS[i].cfg_value);
            end
            else
                send_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].slot, DIRECTED_ROWS[i].pol,
                          DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end
        req_bus.valid <= 1'b0;

        // alternate phases that churn the queue with phases that fill it up
        foreach (PHASE_RELOADS[p])
        begin
            write_slice_reload(PHASE_RELOADS[p]);
            run_random_phase(PHASE_WORDS, (p % 2 == 1) ? 15 : 0);
        end

        while (pending_heads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS round_robin_run_queue");
        else
            $display("FAIL round_robin_run_queue");
        $finish;
    end

endmodule
